// ===== hw/rtl/gbpa_pkg.sv =====
`timescale 1ns / 1ps

package gbpa_pkg;

    // request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // register indexes on the config port
    localparam logic [1:0] REG_GROW_BLOCKS = 2'd0;
    localparam logic [1:0] REG_MAX_BLOCKS  = 2'd1;
    localparam logic [1:0] REG_PAGE_SHIFT  = 2'd2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int BLK_W   = 10;
    localparam int CNT_W   = 11;
    localparam int GROW_W  = 11;
    localparam int MAXB_W  = 11;
    localparam int SHIFT_W = 4;

    localparam logic [CNT_W-1:0]   COUNT_MAX       = 11'd2047;
    localparam logic [GROW_W-1:0]  GROW_RESET      = 11'd16;
    localparam logic [MAXB_W-1:0]  MAX_RESET       = 11'd1024;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET     = 4'd4;
    localparam logic [CNT_W-1:0]   META_PAGE_COUNT = 11'd1;

    typedef struct packed {
        logic [GROW_W-1:0]  grow_blocks;
        logic [MAXB_W-1:0]  max_blocks;
        logic [SHIFT_W-1:0] page_shift;
    } t_cfg;

    typedef struct packed {
        logic rd;
        logic upd;
        logic up;
    } t_page_cmd;

endpackage

// ===== hw/rtl/gbpa_cfg_regs.sv =====
`timescale 1ns / 1ps

module gbpa_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [gbpa_pkg::PDATA_W-1:0]  pwdata,
    output logic [gbpa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output gbpa_pkg::t_cfg                o_cfg
);

    gbpa_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grow_blocks <= gbpa_pkg::GROW_RESET;
            r_cfg.max_blocks  <= gbpa_pkg::MAX_RESET;
            r_cfg.page_shift  <= gbpa_pkg::SHIFT_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                gbpa_pkg::REG_GROW_BLOCKS: begin
                    r_cfg.grow_blocks <= pwdata[gbpa_pkg::GROW_W-1:0];
                end
                gbpa_pkg::REG_MAX_BLOCKS: begin
                    r_cfg.max_blocks <= pwdata[gbpa_pkg::MAXB_W-1:0];
                end
                gbpa_pkg::REG_PAGE_SHIFT: begin
                    r_cfg.page_shift <= pwdata[gbpa_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gbpa_pkg::REG_GROW_BLOCKS: prdata = gbpa_pkg::PDATA_W'(r_cfg.grow_blocks);
            gbpa_pkg::REG_MAX_BLOCKS:  prdata = gbpa_pkg::PDATA_W'(r_cfg.max_blocks);
            gbpa_pkg::REG_PAGE_SHIFT:  prdata = gbpa_pkg::PDATA_W'(r_cfg.page_shift);
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/gbpa_link_ram.sv =====
`timescale 1ns / 1ps

module gbpa_link_ram #(
    parameter int NUM_BLOCKS = 1024,
    localparam int AW = $clog2(NUM_BLOCKS),
    localparam int LW = $clog2(NUM_BLOCKS + 1)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [LW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [LW-1:0] o_rdata
);

    // next-block link of every pushed block, no reset
    logic [LW-1:0] mem [NUM_BLOCKS];
    logic [LW-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== hw/rtl/gbpa_page_ram.sv =====
`timescale 1ns / 1ps

module gbpa_page_ram #(
    parameter int NUM_PAGES = 64,
    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbpa_pkg::t_page_cmd         i_cmd,
    input  logic [PW-1:0]               i_addr,
    output logic [gbpa_pkg::CNT_W-1:0]  o_count,
    output logic                        o_clearing
);

    logic [gbpa_pkg::CNT_W-1:0] mem [NUM_PAGES];
    logic [gbpa_pkg::CNT_W-1:0] r_rdata;
    logic [PW-1:0]              r_addr;
    logic                       r_clr_active;
    logic [PW-1:0]              r_clr_addr;
    logic [gbpa_pkg::CNT_W-1:0] n_count;
    logic [gbpa_pkg::CNT_W-1:0] clr_value;

    assign o_clearing = r_clr_active;
    assign o_count    = n_count;
    assign clr_value  = (r_clr_addr == '0) ? gbpa_pkg::META_PAGE_COUNT : '0;

    // saturating up/down count
    always_comb begin
        if (i_cmd.up) begin
            n_count = (r_rdata == gbpa_pkg::COUNT_MAX) ? r_rdata
                                                       : r_rdata + 11'd1;
        end else begin
            n_count = (r_rdata == '0) ? r_rdata : r_rdata - 11'd1;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == PW'(NUM_PAGES - 1)) begin
                r_clr_active <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            mem[r_clr_addr] <= clr_value;
        end else if (i_cmd.upd) begin
            mem[r_addr] <= n_count;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[i_addr];
            r_addr  <= i_addr;
        end
    end

endmodule

// ===== hw/rtl/growable_block_pool_allocator_core.sv =====
`timescale 1ns / 1ps

// Block pool allocator: a request is taken when start is high and busy is low,
// and its result appears on o_ok, o_granted_block and o_page_in_use for exactly
// one cycle with o_done high, registered out of the execute state; the receiver
// cannot stall, so it must sample the result in that cycle. busy is high in the
// execute state, so a new request waits until the last one leaves it, as the link
// memory and the page count memory that each request reads, modifies and writes
// back have a registered read. After reset is released busy stays high while the
// page count memory is swept to its start values (page 0 holds one for the
// metadata page). Configuration writes over the APB port are taken at any time
// but are meant only while no request is in flight.
module growable_block_pool_allocator_core #(
    parameter int NUM_BLOCKS = 1024,
    parameter int NUM_PAGES  = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [gbpa_pkg::PDATA_W-1:0]  pwdata,
    output logic [gbpa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // request side
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [gbpa_pkg::BLK_W-1:0]    i_block_index,
    // result side
    output logic                          o_done,
    output logic                          o_ok,
    output logic [gbpa_pkg::BLK_W-1:0]    o_granted_block,
    output logic [gbpa_pkg::CNT_W-1:0]    o_page_in_use
);

    // block address, link/null, page address, wide index, sum and page index widths
    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int IW = (LW > gbpa_pkg::BLK_W) ? LW : gbpa_pkg::BLK_W;
    localparam int SW = ((LW > gbpa_pkg::GROW_W) ? LW : gbpa_pkg::GROW_W) + 1;
    localparam int GW = (IW > PW + 1) ? IW : PW + 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    gbpa_pkg::t_cfg      cfg;
    gbpa_pkg::t_page_cmd page_cmd;
    logic                page_clearing;
    logic [gbpa_pkg::CNT_W-1:0] page_count;
    logic [LW-1:0]       link_rdata;

    // allocator state
    logic [LW-1:0] r_free_head;
    logic [LW-1:0] r_watermark;
    logic [LW-1:0] r_committed_top;

    // request held over the execute cycle
    logic          r_op;
    logic          r_ok;
    logic          r_from_list;
    logic          r_pg_valid;
    logic [IW-1:0] r_blk;

    // result registers
    logic                       r_done;
    logic                       r_res_ok;
    logic [gbpa_pkg::BLK_W-1:0] r_res_blk;
    logic [gbpa_pkg::CNT_W-1:0] r_res_cnt;

    // request decode
    logic          accept;
    logic          is_free;
    logic [IW-1:0] idx_ext;
    logic          in_pool;
    logic          head_valid;
    logic          need_grow;
    logic [SW-1:0] limit_sw;
    logic [SW-1:0] top_sw;
    logic          grow_ok;
    logic [LW-1:0] new_top;
    logic          fresh_ok;
    logic          req_ok;
    logic [IW-1:0] req_blk;
    logic [GW-1:0] page_full;
    logic          pg_valid;

    gbpa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start & ~busy;

    assign is_free    = (i_operation == gbpa_pkg::OP_FREE);
    assign idx_ext    = IW'(i_block_index);
    assign in_pool    = idx_ext < IW'(NUM_BLOCKS);
    assign head_valid = r_free_head < LW'(NUM_BLOCKS);

    // grow the committed region only once every fresh block is out
    assign need_grow = r_watermark >= r_committed_top;
    assign limit_sw  = (SW'(cfg.max_blocks) > SW'(NUM_BLOCKS)) ? SW'(NUM_BLOCKS)
                                                               : SW'(cfg.max_blocks);
    assign top_sw    = SW'(r_committed_top) + SW'(cfg.grow_blocks);
    assign grow_ok   = need_grow && (cfg.grow_blocks != '0) && (top_sw <= limit_sw);
    assign new_top   = grow_ok ? LW'(top_sw) : r_committed_top;
    assign fresh_ok  = r_watermark < new_top;

    always_comb begin
        if (is_free) begin
            req_ok  = in_pool;
            req_blk = idx_ext;
        end else if (head_valid) begin
            req_ok  = 1'b1;
            req_blk = IW'(r_free_head);
        end else begin
            req_ok  = fresh_ok;
            req_blk = fresh_ok ? IW'(r_watermark) : '0;
        end
    end

    // page of the affected block; pages past the table keep no count
    assign page_full = GW'(req_blk) >> cfg.page_shift;
    assign pg_valid  = page_full < GW'(NUM_PAGES);

    // the link of a freed block is written at acceptance; the head's link is
    // read at the same edge for a pop from the list
    gbpa_link_ram #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (accept & is_free & in_pool),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (r_free_head),
        .i_re    (accept & ~is_free & head_valid),
        .i_raddr (r_free_head[AW-1:0]),
        .o_rdata (link_rdata)
    );

    // count read at acceptance, written back in the execute cycle
    assign page_cmd.rd  = accept;
    assign page_cmd.upd = (r_state == S_EXEC) & r_ok & r_pg_valid;
    assign page_cmd.up  = (r_op == gbpa_pkg::OP_ALLOC);

    gbpa_page_ram #(
        .NUM_PAGES (NUM_PAGES)
    ) u_page (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (page_cmd),
        .i_addr     (page_full[PW-1:0]),
        .o_count    (page_count),
        .o_clearing (page_clearing)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (!page_clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // allocator state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head     <= LW'(NUM_BLOCKS);
            r_watermark     <= '0;
            r_committed_top <= '0;
        end else if (accept) begin
            if (is_free) begin
                if (in_pool) begin
                    r_free_head <= LW'(idx_ext);
                end
            end else if (!head_valid) begin
                r_committed_top <= new_top;
                if (fresh_ok) begin
                    r_watermark <= r_watermark + 1'b1;
                end
            end
        end else if ((r_state == S_EXEC) && r_from_list) begin
            // pop: the head moves to the link read at acceptance
            r_free_head <= link_rdata;
        end
    end

    // request context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_from_list <= 1'b0;
            r_ok        <= 1'b0;
        end else if (accept) begin
            r_from_list <= ~is_free & head_valid;
            r_ok        <= req_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_operation;
            r_blk      <= req_blk;
            r_pg_valid <= pg_valid;
        end
    end

    // result registers, one strobe per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_res_ok  <= r_ok;
            r_res_blk <= r_blk[gbpa_pkg::BLK_W-1:0];
            r_res_cnt <= (r_ok && r_pg_valid) ? page_count : '0;
        end
    end

    assign o_done          = r_done;
    assign o_ok            = r_res_ok;
    assign o_granted_block = r_res_blk;
    assign o_page_in_use   = r_res_cnt;

endmodule
